/* src/tms_pkg.sv */
// Shared types and constants for the Turing machine step engine.
package tms_pkg;

   localparam int STATE_COUNT = 32;
   localparam int STATE_W = 5;
   localparam int TAPE_DEPTH = 1024;
   localparam int TAPE_ADDR_W = 10;
   localparam int TAPE_LEN_W = 11;
   localparam int SYMBOL_W = 8;

   localparam logic [SYMBOL_W-1:0] KEEP_SYMBOL = 8'd92;

   localparam logic [2:0] MODE_LOAD = 3'd0;
   localparam logic [2:0] MODE_ADD = 3'd1;
   localparam logic [2:0] MODE_FLAGS = 3'd2;
   localparam logic [2:0] MODE_START = 3'd3;
   localparam logic [2:0] MODE_STEP = 3'd4;

   localparam logic [2:0] STATUS_DONE = 3'd0;
   localparam logic [2:0] STATUS_FULL = 3'd1;
   localparam logic [2:0] STATUS_RUNNING = 3'd2;
   localparam logic [2:0] STATUS_ACCEPTED = 3'd3;
   localparam logic [2:0] STATUS_REJECTED = 3'd4;
   localparam logic [2:0] STATUS_OFF_TAPE = 3'd5;
   localparam logic [2:0] STATUS_NOT_STARTED = 3'd6;

   typedef struct packed {
      logic [2:0] mode;
      logic [TAPE_ADDR_W-1:0] position;
      logic [SYMBOL_W-1:0] symbol;
      logic [STATE_W-1:0] state_id;
      logic [STATE_W-1:0] next_state;
      logic [SYMBOL_W-1:0] write_symbol;
      logic move_right;
      logic is_accept;
      logic is_reject;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [STATE_W-1:0] state_out;
      logic [TAPE_ADDR_W-1:0] head_out;
      logic [SYMBOL_W-1:0] read_symbol;
   } rsp_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] match;
      logic [STATE_W-1:0] target;
      logic [SYMBOL_W-1:0] put;
      logic right;
   } rule_type;

   typedef struct packed {
      logic hit;
      rule_type rule;
   } match_type;

   typedef struct packed {
      logic accept;
      logic reject;
   } flags_type;

   typedef struct packed {
      logic en;
      logic [TAPE_ADDR_W-1:0] addr;
      logic [SYMBOL_W-1:0] data;
   } tape_wr_type;

endpackage

/* src/turing_machine_step.sv */
// Top level of the Turing machine step engine: control, state registers and result register.
// A request is captured together with the registered read of the tape and transition
// memories; its result is registered, with the write-back of tape, head and state, once
// the result register is free. No new request is taken until the current one finishes.
// Reset is synchronous: it clears the control, slot counts, head, state and started flag,
// restores the default flags and tape length; the memories keep undefined contents.
module turing_machine_step
   import tms_pkg::*;
#(
   parameter int SLOTS_PER_STATE = 8
)
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [TAPE_LEN_W-1:0] csr_wr_data
);

   localparam int SLOT_CNT_W = $clog2(SLOTS_PER_STATE + 1);
   localparam int SLOT_IDX_W = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   req_type req_ff;
   logic [STATE_W-1:0] cur_state_ff, cur_state_in;
   logic [TAPE_ADDR_W-1:0] head_ff, head_in;
   logic started_ff, started_in;
   logic [TAPE_LEN_W-1:0] tape_len_ff;
   logic [SLOT_CNT_W-1:0] slot_cnt_ff [STATE_COUNT];
   flags_type flags_ff [STATE_COUNT];
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic out_free;
   logic finish;
   logic [SLOT_CNT_W-1:0] add_cnt;
   logic [SLOT_CNT_W-1:0] step_cnt;
   logic [TAPE_LEN_W-1:0] eff_len;
   logic [TAPE_LEN_W-1:0] head_plus;
   logic [SYMBOL_W-1:0] tape_rd;
   rule_type [SLOTS_PER_STATE-1:0] rule_row;
   match_type match;
   tape_wr_type tape_wr;
   logic rule_we;
   rule_type new_rule;
   logic [2:0] status;
   logic [SYMBOL_W-1:0] seen;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish = (state_ff == ST_EXEC) && out_free;
   assign add_cnt = slot_cnt_ff[req_ff.state_id];
   assign step_cnt = slot_cnt_ff[cur_state_ff];
   assign head_plus = {1'b0, head_ff} + TAPE_LEN_W'(1);

   assign new_rule.match = req_ff.symbol;
   assign new_rule.target = req_ff.next_state;
   assign new_rule.put = req_ff.write_symbol;
   assign new_rule.right = req_ff.move_right;

   tms_tape_mem u_tape_mem (
      .clock   (clock),
      .wr      (tape_wr),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (tape_rd)
   );

   tms_rule_mem #(
      .SlotCount (SLOTS_PER_STATE),
      .SlotIdxW  (SLOT_IDX_W)
   ) u_rule_mem (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (req_ff.state_id),
      .wr_slot (add_cnt[SLOT_IDX_W-1:0]),
      .wr_rule (new_rule),
      .rd_en   (accept),
      .rd_addr (cur_state_ff),
      .rd_row  (rule_row)
   );

   tms_rule_match #(
      .SlotCount (SLOTS_PER_STATE),
      .CntW      (SLOT_CNT_W)
   ) u_rule_match (
      .row    (rule_row),
      .count  (step_cnt),
      .seen   (tape_rd),
      .result (match)
   );

   always_comb begin
      if (tape_len_ff == '0) begin
         eff_len = TAPE_LEN_W'(1);
      end else if (tape_len_ff > TAPE_LEN_W'(TAPE_DEPTH)) begin
         eff_len = TAPE_LEN_W'(TAPE_DEPTH);
      end else begin
         eff_len = tape_len_ff;
      end
   end

   always_comb begin
      cur_state_in = cur_state_ff;
      head_in = head_ff;
      started_in = started_ff;
      status = STATUS_DONE;
      seen = '0;
      tape_wr = '0;
      rule_we = 1'b0;
      case (req_ff.mode)
         MODE_LOAD: begin
            tape_wr.en = finish;
            tape_wr.addr = req_ff.position;
            tape_wr.data = req_ff.symbol;
         end
         MODE_ADD: begin
            if (add_cnt >= SLOT_CNT_W'(SLOTS_PER_STATE)) begin
               status = STATUS_FULL;
            end else begin
               rule_we = finish;
            end
         end
         MODE_START: begin
            cur_state_in = req_ff.state_id;
            head_in = '0;
            started_in = 1'b1;
         end
         MODE_STEP: begin
            if (!started_ff) begin
               status = STATUS_NOT_STARTED;
            end else begin
               seen = tape_rd;
               status = STATUS_REJECTED;
               if (match.hit) begin
                  tape_wr.en = finish && (match.rule.put != KEEP_SYMBOL);
                  tape_wr.addr = head_ff;
                  tape_wr.data = match.rule.put;
                  if (!match.rule.right || (head_plus < eff_len)) begin
                     if (!match.rule.right) begin
                        head_in = (head_ff == '0) ? '0 : head_ff - TAPE_ADDR_W'(1);
                     end else begin
                        head_in = head_plus[TAPE_ADDR_W-1:0];
                     end
                     cur_state_in = match.rule.target;
                     if (flags_ff[match.rule.target].accept) begin
                        status = STATUS_ACCEPTED;
                     end else if (flags_ff[match.rule.target].reject) begin
                        status = STATUS_REJECTED;
                     end else begin
                        status = STATUS_RUNNING;
                     end
                  end else begin
                     status = STATUS_OFF_TAPE;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in.status = status;
      rsp_in.state_out = cur_state_in;
      rsp_in.head_out = head_in;
      rsp_in.read_symbol = seen;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_state_ff <= '0;
         head_ff <= '0;
         started_ff <= 1'b0;
         tape_len_ff <= TAPE_LEN_W'(TAPE_DEPTH);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STATE_COUNT; i++) begin
            slot_cnt_ff[i] <= '0;
            flags_ff[i].accept <= (i == 0);
            flags_ff[i].reject <= (i == 1);
         end
      end else begin
         if (csr_wr_en) begin
            tape_len_ff <= csr_wr_data;
         end
         if (accept) begin
            state_ff <= ST_EXEC;
         end else if (finish) begin
            state_ff <= ST_IDLE;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish) begin
            cur_state_ff <= cur_state_in;
            head_ff <= head_in;
            started_ff <= started_in;
            if (rule_we) begin
               slot_cnt_ff[req_ff.state_id] <= add_cnt + SLOT_CNT_W'(1);
            end
            if (req_ff.mode == MODE_FLAGS) begin
               flags_ff[req_ff.state_id].accept <= req_ff.is_accept;
               flags_ff[req_ff.state_id].reject <= req_ff.is_reject;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_accept_enters_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execution");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result appeared without an executed request");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (state_ff == ST_IDLE)) |->
         ((rsp_ff.head_out == head_ff) && (rsp_ff.state_out == cur_state_ff)))
      else $error("pending result disagrees with head or state");

   a_slot_count_bound: assert property (@(posedge clock) disable iff (reset)
      finish && rule_we |-> (add_cnt < SLOT_CNT_W'(SLOTS_PER_STATE)))
      else $error("transition written past the end of a row");

endmodule

/* src/tms_tape_mem.sv */
// Tape memory with one write port and one registered read port.
module tms_tape_mem
   import tms_pkg::*;
(
   input  logic clock,
   input  tape_wr_type wr,
   input  logic rd_en,
   input  logic [TAPE_ADDR_W-1:0] rd_addr,
   output logic [SYMBOL_W-1:0] rd_data
);

   logic [SYMBOL_W-1:0] tape_mem [TAPE_DEPTH];
   logic [SYMBOL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         tape_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= tape_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tms_rule_mem.sv */
// Transition table memory: one row of slots per state, written one slot at a time.
module tms_rule_mem
   import tms_pkg::*;
#(
   parameter int SlotCount = 8,
   parameter int SlotIdxW = 3
)
(
   input  logic clock,
   input  logic wr_en,
   input  logic [STATE_W-1:0] wr_addr,
   input  logic [SlotIdxW-1:0] wr_slot,
   input  rule_type wr_rule,
   input  logic rd_en,
   input  logic [STATE_W-1:0] rd_addr,
   output rule_type [SlotCount-1:0] rd_row
);

   rule_type [SlotCount-1:0] row_mem [STATE_COUNT];
   rule_type [SlotCount-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr][wr_slot] <= wr_rule;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

/* src/tms_rule_match.sv */
// Picks the first filled slot of a transition row whose read symbol matches.
module tms_rule_match
   import tms_pkg::*;
#(
   parameter int SlotCount = 8,
   parameter int CntW = 4
)
(
   input  rule_type [SlotCount-1:0] row,
   input  logic [CntW-1:0] count,
   input  logic [SYMBOL_W-1:0] seen,
   output match_type result
);

   always_comb begin
      result = '0;
      for (int i = SlotCount - 1; i >= 0; i--) begin
         if ((CntW'(i) < count) && (row[i].match == seen)) begin
            result.hit = 1'b1;
            result.rule = row[i];
         end
      end
   end

endmodule

/* dv/turing_machine_step_tb.sv */
// Self-checking testbench for the Turing machine step engine, with its own predictor.
`timescale 1ns / 100ps

module turing_machine_step_tb;
   import tms_pkg::*;

   localparam int SLOTS = 8;
   localparam int PHASES = 9;
   localparam int PHASE_REQUESTS = 160;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam rsp_type DONE_AT_RESET = '{status: STATUS_DONE, default: '0};

   typedef struct {
      req_type req;
      bit typed;
      rsp_type want;
   } directed_row;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [TAPE_LEN_W-1:0] csr_wr_data;

   logic [SYMBOL_W-1:0] tape_img [TAPE_DEPTH];
   bit tape_set [TAPE_DEPTH];
   rule_type rules [STATE_COUNT][SLOTS];
   int rule_count [STATE_COUNT];
   flags_type state_flag [STATE_COUNT];
   logic [STATE_W-1:0] mach_state;
   int head_pos;
   bit mach_started;
   int tape_len_cfg;

   rsp_type awaited_results [$];
   directed_row directed_rows [$];
   int phase_len [PHASES] = '{1024, 0, 6, 2047, 1, 20, 1024, 3, 1025};
   int status_hits [8];
   int send_idle;
   int recv_idle;
   int hold_cycles;
   bit held_once;
   int checked_count;
   int sent_count;
   int error_count;
   int settings_used;

   turing_machine_step uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d results still awaited.", awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic rsp_type next_machine_result(input req_type r);
      rsp_type res;
      rule_type hit;
      bit fired;
      int eff_len;
      res = '0;
      res.status = STATUS_DONE;
      case (r.mode)
         MODE_LOAD: begin
            tape_img[r.position] = r.symbol;
            tape_set[r.position] = 1'b1;
         end
         MODE_ADD: begin
            if (rule_count[r.state_id] >= SLOTS) begin
               res.status = STATUS_FULL;
            end else begin
               rules[r.state_id][rule_count[r.state_id]] =
                  '{r.symbol, r.next_state, r.write_symbol, r.move_right};
               rule_count[r.state_id]++;
            end
         end
         MODE_FLAGS: begin
            state_flag[r.state_id] = '{r.is_accept, r.is_reject};
         end
         MODE_START: begin
            mach_state = r.state_id;
            head_pos = 0;
            mach_started = 1'b1;
         end
         MODE_STEP: begin
            if (!mach_started) begin
               res.status = STATUS_NOT_STARTED;
            end else begin
               eff_len = (tape_len_cfg == 0) ? 1 :
                         (tape_len_cfg > TAPE_DEPTH) ? TAPE_DEPTH : tape_len_cfg;
               res.read_symbol = tape_img[head_pos];
               res.status = STATUS_REJECTED;
               fired = 1'b0;
               for (int i = 0; i < rule_count[mach_state] && !fired; i++) begin
                  hit = rules[mach_state][i];
                  if (hit.match == res.read_symbol) begin
                     fired = 1'b1;
                     if (hit.put != KEEP_SYMBOL) tape_img[head_pos] = hit.put;
                     if (!hit.right) begin
                        if (head_pos > 0) head_pos--;
                     end else if (head_pos + 1 >= eff_len) begin
                        res.status = STATUS_OFF_TAPE;
                     end else begin
                        head_pos++;
                     end
                     if (res.status != STATUS_OFF_TAPE) begin
                        mach_state = hit.target;
                        if (state_flag[hit.target].accept) res.status = STATUS_ACCEPTED;
                        else if (state_flag[hit.target].reject) res.status = STATUS_REJECTED;
                        else res.status = STATUS_RUNNING;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      res.state_out = mach_state;
      res.head_out = TAPE_ADDR_W'(head_pos);
      status_hits[res.status]++;
      return res;
   endfunction

   function automatic logic [SYMBOL_W-1:0] pick_symbol();
      if ($urandom_range(99) < 85) return SYMBOL_W'($urandom_range(3));
      return SYMBOL_W'($urandom_range(255));
   endfunction

   function automatic logic [STATE_W-1:0] pick_state();
      if ($urandom_range(9) < 7) return STATE_W'($urandom_range(7));
      return STATE_W'($urandom_range(STATE_COUNT - 1));
   endfunction

   // Most requests are steps of a running machine; the rest build its program and tape, restart it or use spare modes.
   function automatic req_type random_request();
      req_type r;
      bit [63:0] noise;
      int pick;
      noise = {$urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 10) begin
         r.mode = MODE_LOAD;
         if ($urandom_range(9) != 0) r.position = TAPE_ADDR_W'($urandom_range(63));
         r.symbol = pick_symbol();
      end else if (pick < 22) begin
         r.mode = MODE_ADD;
         r.state_id = pick_state();
         r.next_state = pick_state();
         r.symbol = pick_symbol();
         if ($urandom_range(4) == 0) r.write_symbol = KEEP_SYMBOL;
         else if ($urandom_range(3) != 0) r.write_symbol = pick_symbol();
      end else if (pick < 27) begin
         r.mode = MODE_FLAGS;
      end else if (pick < 32) begin
         r.mode = MODE_START;
         r.state_id = pick_state();
      end else if (pick < 35) begin
         r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end else if (!tape_set[head_pos]) begin
         r.mode = MODE_LOAD;
         r.position = TAPE_ADDR_W'(head_pos);
         r.symbol = pick_symbol();
      end else begin
         r.mode = MODE_STEP;
      end
      return r;
   endfunction

   function automatic req_type mkreq(input logic [2:0] m, input int pos, input int sym,
                                     input int sid, input int nxt, input int wsym,
                                     input bit rt, input bit acc, input bit rej);
      return '{m, TAPE_ADDR_W'(pos), SYMBOL_W'(sym), STATE_W'(sid), STATE_W'(nxt),
               SYMBOL_W'(wsym), rt, acc, rej};
   endfunction

   task automatic add_row(input req_type r, input bit typed, input rsp_type w);
      directed_rows.push_back('{r, typed, w});
   endtask

   task automatic send_request(input req_type r, input rsp_type want);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle) gap++;
      awaited_results.push_back(want);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_tape_length(input int len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= TAPE_LEN_W'(len);
      tape_len_cfg = len;
      settings_used++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t: unexpected result status %0d state %0d head %0d read 0x%02h",
                  $time, got.status, got.state_out, got.head_out, got.read_symbol);
         error_count++;
      end else begin
         want = awaited_results.pop_front();
         if (got !== want) begin
            $display("%0t: result %0d expected status %0d state %0d head %0d read 0x%02h,",
                     $time, checked_count, want.status, want.state_out, want.head_out,
                     want.read_symbol);
            $display("   got status %0d state %0d head %0d read 0x%02h",
                     got.status, got.state_out, got.head_out, got.read_symbol);
            error_count++;
         end
      end
      checked_count++;
   endtask

   initial begin
      rsp_ready = 1'b0;
      hold_cycles = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
         if (!held_once && checked_count >= 1100) begin
            held_once = 1'b1;
            hold_cycles = 300;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      rsp_type want;
      for (int s = 0; s < STATE_COUNT; s++) begin
         rule_count[s] = 0;
         state_flag[s] = '{accept: (s == 0), reject: (s == 1)};
      end
      foreach (tape_set[c]) tape_set[c] = 1'b0;
      mach_state = '0;
      head_pos = 0;
      mach_started = 1'b0;
      tape_len_cfg = TAPE_DEPTH;
      send_idle = 9;
      recv_idle = 61;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              '{STATUS_NOT_STARTED, 5'd0, 10'd0, 8'd0});
      add_row(mkreq(MODE_LOAD, 0, 'h41, 0, 0, 0, 0, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_LOAD, 1023, 'hFF, 31, 31, 255, 1, 1, 1), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_LOAD, 1, 'h00, 0, 0, 0, 0, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_SPARE_HI, 1023, 255, 31, 31, 255, 1, 1, 1), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_ADD, 0, 'h41, 2, 3, KEEP_SYMBOL, 1, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_ADD, 0, 'h00, 3, 0, 'hAA, 0, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_ADD, 0, 'hAA, 3, 5, 'h33, 1, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_ADD, 0, 'h41, 4, 1, KEEP_SYMBOL, 0, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_ADD, 0, 'hFF, 31, 31, 'h00, 1, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_FLAGS, 0, 0, 31, 0, 0, 0, 1, 1), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_FLAGS, 0, 0, 3, 0, 0, 0, 0, 0), 1'b1, DONE_AT_RESET);
      add_row(mkreq(MODE_START, 0, 0, 2, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_START, 0, 0, 2, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_START, 0, 0, 4, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);
      add_row(mkreq(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, DONE_AT_RESET);

      // A two-cell tape lets the directed steps reach the right edge.
      write_tape_length(2);
      foreach (directed_rows[i]) begin
         want = next_machine_result(directed_rows[i].req);
         if (directed_rows[i].typed) want = directed_rows[i].want;
         send_request(directed_rows[i].req, want);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         send_idle = (p < 3) ? 9 : (p < 6) ? 61 : 0;
         recv_idle = (p < 3) ? 61 : (p < 6) ? 9 : 0;
         write_tape_length(phase_len[p]);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            req_type r;
            r = random_request();
            send_request(r, next_machine_result(r));
         end
      end
      drain();

      $display("Checked %0d results from %0d requests over %0d tape-length settings.",
               checked_count, sent_count, settings_used);
      $display("Outcomes: %0d running, %0d accepted, %0d rejected, %0d off tape, %0d full.",
               status_hits[STATUS_RUNNING], status_hits[STATUS_ACCEPTED],
               status_hits[STATUS_REJECTED], status_hits[STATUS_OFF_TAPE],
               status_hits[STATUS_FULL]);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/tms_pkg.sv
src/tms_tape_mem.sv
src/tms_rule_mem.sv
src/tms_rule_match.sv
src/turing_machine_step.sv
dv/turing_machine_step_tb.sv
